/* rtl/nps_pkg.sv */
`default_nettype none

package nps_pkg;

	// field widths fixed by the item format
	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int PRI_W  = 8;
	localparam int TIME_W = 21;
	localparam int NUM_W  = 5;

	// one stored job as it travels along the chain
	typedef struct packed {
		logic [ARR_W-1:0] arrival;
		logic [BUR_W-1:0] burst;
		logic [PRI_W-1:0] prio;
	} job_t;

endpackage

`default_nettype wire

/* rtl/nps_cell.sv */
`default_nettype none

module nps_cell
	import nps_pkg::*;
#(
	parameter int IDX_W = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             shift,
	input  wire job_t             job_in,
	input  wire logic [IDX_W-1:0] idx_in,
	input  wire logic             pend_in,
	input  wire logic             retire_en,
	input  wire logic [IDX_W-1:0] retire_idx,
	output job_t                  job_out,
	output logic [IDX_W-1:0]      idx_out,
	output logic                  pend_out
);

	job_t             job_q;
	logic [IDX_W-1:0] idx_q;
	logic             pend_q;

	// pending flag: taken from the neighbor on a shift, dropped when retired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (shift) begin
			pend_q <= pend_in;
		end else if (retire_en && (idx_q == retire_idx)) begin
			pend_q <= 1'b0;
		end
	end

	// job payload and its load-order index
	always_ff @(posedge clk) begin
		if (shift) begin
			job_q <= job_in;
			idx_q <= idx_in;
		end
	end

	assign job_out  = job_q;
	assign idx_out  = idx_q;
	assign pend_out = pend_q;

endmodule

`default_nettype wire

/* rtl/nps_sel.sv */
`default_nettype none

module nps_sel
	import nps_pkg::*;
#(
	parameter int IDX_W = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              first,
	input  wire job_t              head,
	input  wire logic [IDX_W-1:0]  head_idx,
	input  wire logic              head_pend,
	input  wire logic [TIME_W-1:0] cur_time,
	output logic                   found,
	output job_t                   pick,
	output logic [IDX_W-1:0]       pick_idx,
	output logic [ARR_W-1:0]       earliest
);

	logic             found_q;
	logic             have_q;
	job_t             pick_q;
	logic [IDX_W-1:0] pick_idx_q;
	logic [ARR_W-1:0] earliest_q;

	logic base_found;
	logic base_have;
	logic elig;
	logic better;
	logic take;
	logic sooner;

	// one comparator looks at the job at the head of the chain each cycle of a scan
	always_comb begin
		base_found = found_q & ~first;
		base_have  = have_q & ~first;
		elig       = head_pend && ({{(TIME_W-ARR_W){1'b0}}, head.arrival} <= cur_time);
		better     = !base_found || (head.prio > pick_q.prio) ||
		             ((head.prio == pick_q.prio) && (head_idx < pick_idx_q));
		take       = elig && better;
		sooner     = head_pend && (!base_have || (head.arrival < earliest_q));
	end

	// scan flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			have_q  <= 1'b0;
		end else if (en) begin
			found_q <= base_found | take;
			have_q  <= base_have | head_pend;
		end
	end

	// best candidate and earliest pending arrival
	always_ff @(posedge clk) begin
		if (en && take) begin
			pick_q     <= head;
			pick_idx_q <= head_idx;
		end
		if (en && sooner) begin
			earliest_q <= head.arrival;
		end
	end

	assign found    = found_q;
	assign pick     = pick_q;
	assign pick_idx = pick_idx_q;
	assign earliest = earliest_q;

endmodule

`default_nettype wire

/* rtl/nonpreemptive_priority_scheduler.sv */
// Non-preemptive priority scheduler. Jobs are loaded one item per cycle into a
// circular chain of MAX_PROCS cells; a job offered when the chain is full is
// dropped, and the item with last_job set closes the set and starts the
// schedule from tick zero. Each decision rotates the whole chain once past a
// single comparator; when the scheduler is idle, time first jumps to the next
// arrival and the chain is rotated once more. The highest priority among
// arrived jobs wins, ties go to the lowest load index. Results come out in
// scheduling order through an output register; the input stalls from the last
// job until the final result of the set has been loaded into that register.
`default_nettype none

module nonpreemptive_priority_scheduler
	import nps_pkg::*;
#(
	parameter int MAX_PROCS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [ARR_W-1:0]  arrival_time,
	input  wire logic [BUR_W-1:0]  burst_length,
	input  wire logic [PRI_W-1:0]  job_priority,
	input  wire logic              last_job,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [NUM_W-1:0]       job_number,
	output logic [TIME_W-1:0]      start_time,
	output logic [TIME_W-1:0]      finish_time,
	output logic [TIME_W-1:0]      turnaround_time,
	output logic [TIME_W-1:0]      waiting_time,
	output logic [TIME_W-1:0]      response_time,
	output logic                   last_result
);

	localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W = $clog2(MAX_PROCS + 1);
	localparam int EXT_W = (IDX_W + 1 > NUM_W) ? IDX_W + 1 : NUM_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_EMIT   = 3'd3;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rem_q;
	logic [IDX_W-1:0]  scan_q;
	logic [TIME_W-1:0] time_q;

	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] finish_q;
	logic [TIME_W-1:0] resp_q;
	logic [BUR_W-1:0]  burst_q;
	logic [IDX_W-1:0]  num_q;

	logic              out_valid_q;
	logic [NUM_W-1:0]  job_number_q;
	logic [TIME_W-1:0] start_time_q;
	logic [TIME_W-1:0] finish_time_q;
	logic [TIME_W-1:0] turnaround_time_q;
	logic [TIME_W-1:0] response_time_q;
	logic              last_result_q;

	logic              in_go;
	logic              room;
	logic              load;
	logic              scanning;
	logic              shift;
	logic              emit_go;
	logic [CNT_W-1:0]  count_next;

	job_t              new_job;
	job_t              chain_job  [MAX_PROCS];
	logic [IDX_W-1:0]  chain_idx  [MAX_PROCS];
	logic [MAX_PROCS-1:0] pend_vec;

	logic              found;
	job_t              pick;
	logic [IDX_W-1:0]  pick_idx;
	logic [ARR_W-1:0]  earliest;
	logic              retire_en;

	// handshake and chain control
	always_comb begin
		in_go      = in_valid && !in_stall;
		room       = count_q < CNT_W'(MAX_PROCS);
		load       = in_go && room;
		scanning   = (state_q == ST_SCAN);
		shift      = load || scanning;
		emit_go    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
		retire_en  = (state_q == ST_DECIDE) && found;
		count_next = count_q + CNT_W'(room);
		new_job.arrival = arrival_time;
		new_job.burst   = burst_length;
		new_job.prio    = job_priority;
	end

	assign in_stall = (state_q != ST_IDLE);

	// circular chain of job cells, head is the last cell
	for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
		job_t             cin_job;
		logic [IDX_W-1:0] cin_idx;
		logic             cin_pend;
		logic             cout_pend;

		if (i == 0) begin : g_first
			assign cin_job  = load ? new_job : chain_job[MAX_PROCS-1];
			assign cin_idx  = load ? count_q[IDX_W-1:0] : chain_idx[MAX_PROCS-1];
			assign cin_pend = load ? 1'b1 : pend_vec[MAX_PROCS-1];
		end else begin : g_next
			assign cin_job  = chain_job[i-1];
			assign cin_idx  = chain_idx[i-1];
			assign cin_pend = pend_vec[i-1];
		end

		nps_cell #(
			.IDX_W(IDX_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (shift),
			.job_in    (cin_job),
			.idx_in    (cin_idx),
			.pend_in   (cin_pend),
			.retire_en (retire_en),
			.retire_idx(pick_idx),
			.job_out   (chain_job[i]),
			.idx_out   (chain_idx[i]),
			.pend_out  (cout_pend)
		);

		assign pend_vec[i] = cout_pend;
	end

	// selection over one full rotation
	nps_sel #(
		.IDX_W(IDX_W)
	) u_sel (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (scanning),
		.first    (scan_q == '0),
		.head     (chain_job[MAX_PROCS-1]),
		.head_idx (chain_idx[MAX_PROCS-1]),
		.head_pend(pend_vec[MAX_PROCS-1]),
		.cur_time (time_q),
		.found    (found),
		.pick     (pick),
		.pick_idx (pick_idx),
		.earliest (earliest)
	);

	// scheduler sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rem_q   <= '0;
			scan_q  <= '0;
			time_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_go) begin
						count_q <= count_next;
						if (last_job) begin
							rem_q   <= count_next;
							scan_q  <= '0;
							time_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + IDX_W'(1);
					if (scan_q == IDX_W'(MAX_PROCS - 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					scan_q <= '0;
					if (found) begin
						time_q  <= TIME_W'(time_q + {{(TIME_W-BUR_W){1'b0}}, pick.burst});
						state_q <= ST_EMIT;
					end else begin
						time_q  <= {{(TIME_W-ARR_W){1'b0}}, earliest};
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						rem_q <= rem_q - CNT_W'(1);
						if (rem_q == CNT_W'(1)) begin
							count_q <= '0;
							time_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// first half of the result: start, finish and response, with the burst and job index
	always_ff @(posedge clk) begin
		if (retire_en) begin
			start_q  <= time_q;
			finish_q <= TIME_W'(time_q + {{(TIME_W-BUR_W){1'b0}}, pick.burst});
			resp_q   <= TIME_W'(time_q - {{(TIME_W-ARR_W){1'b0}}, pick.arrival});
			burst_q  <= pick.burst;
			num_q    <= pick_idx;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload, turnaround is response plus burst
	always_ff @(posedge clk) begin
		if (emit_go) begin
			job_number_q      <= NUM_W'(EXT_W'(num_q) + EXT_W'(1));
			start_time_q      <= start_q;
			finish_time_q     <= finish_q;
			turnaround_time_q <= TIME_W'(resp_q + {{(TIME_W-BUR_W){1'b0}}, burst_q});
			response_time_q   <= resp_q;
			last_result_q     <= (rem_q == CNT_W'(1));
		end
	end

	assign out_valid       = out_valid_q;
	assign job_number      = job_number_q;
	assign start_time      = start_time_q;
	assign finish_time     = finish_time_q;
	assign turnaround_time = turnaround_time_q;
	assign waiting_time    = response_time_q;
	assign response_time   = response_time_q;
	assign last_result     = last_result_q;

	// a scheduled job clears exactly one pending flag
	assert property (@(posedge clk) disable iff (!arst_n)
		retire_en |=> ($countones(pend_vec) + 1) == $past($countones(pend_vec)))
	else $error("retire did not clear exactly one pending job");

	// while scheduling there is always some job still pending
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DECIDE) |-> (pend_vec != '0))
	else $error("scheduling with no pending job");

	// a result is emitted only while jobs remain
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |-> (rem_q != '0))
	else $error("result emitted with no job remaining");

endmodule

`default_nettype wire
